@@ rtl/alm_pkg.sv @@
package alm_pkg;

	localparam int CHANNELS = 2;
	localparam int CH_W = 1;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W = 16;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = 44;

	localparam int RMS_DEPTH = 8192;
	localparam int RMS_POS_W = $clog2(RMS_DEPTH);
	localparam int RMS_WIN_W = 14;
	localparam int RMS_AW = CH_W + RMS_POS_W;
	localparam int RMS_WORDS = CHANNELS * RMS_DEPTH;

	localparam int PEAK_DEPTH = 65536;
	localparam int PEAK_POS_W = $clog2(PEAK_DEPTH);
	localparam int PEAK_WIN_W = 17;
	localparam int NODE_W = PEAK_POS_W + 1;
	localparam int TREE_AW = CH_W + NODE_W;
	localparam int TREE_WORDS = CHANNELS * 2 * PEAK_DEPTH;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_RMS_WINDOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW = 1'd1;

	localparam logic [RMS_WIN_W-1:0] RMS_WINDOW_RST = 14'd4410;
	localparam logic [PEAK_WIN_W-1:0] PEAK_WINDOW_RST = 17'd65536;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RRD,
		ST_ROLD,
		ST_RSUB,
		ST_LEAF,
		ST_PAR,
		ST_CMP,
		ST_DONE,
		ST_OUT
	} state_t;

	function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] b);
		magnitude = b[SAMPLE_W-1] ? MAG_W'(~b + 1'b1) : MAG_W'(b);
	endfunction

	function automatic logic [RMS_WIN_W-1:0] clamp_rms(input logic [RMS_WIN_W-1:0] w);
		if (w == '0) begin
			clamp_rms = RMS_WIN_W'(1);
		end else if (w > RMS_WIN_W'(RMS_DEPTH)) begin
			clamp_rms = RMS_WIN_W'(RMS_DEPTH);
		end else begin
			clamp_rms = w;
		end
	endfunction

	function automatic logic [PEAK_WIN_W-1:0] clamp_peak(input logic [PEAK_WIN_W-1:0] w);
		if (w == '0) begin
			clamp_peak = PEAK_WIN_W'(1);
		end else if (w > PEAK_WIN_W'(PEAK_DEPTH)) begin
			clamp_peak = PEAK_WIN_W'(PEAK_DEPTH);
		end else begin
			clamp_peak = w;
		end
	endfunction

	// smallest power of two not below w (w >= 1)
	function automatic logic [PEAK_WIN_W-1:0] pow2_ceil(input logic [PEAK_WIN_W-1:0] w);
		logic [PEAK_WIN_W-1:0] x;
		x = w - 1'b1;
		x = x | (x >> 1);
		x = x | (x >> 2);
		x = x | (x >> 4);
		x = x | (x >> 8);
		x = x | (x >> 16);
		pow2_ceil = x + 1'b1;
	endfunction

endpackage

@@ rtl/alm_in_if.sv @@
interface alm_in_if import alm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CH_W-1:0] channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

@@ rtl/alm_out_if.sv @@
interface alm_out_if import alm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CH_W-1:0] channel_out;
	logic [SUM_W-1:0] sum_of_squares;
	logic [MAG_W-1:0] window_peak;
	logic [MAG_W-1:0] overall_peak;

	modport source (output valid, output channel_out, output sum_of_squares,
		output window_peak, output overall_peak, input ready);
	modport sink (input valid, input channel_out, input sum_of_squares,
		input window_peak, input overall_peak, output ready);
endinterface

@@ rtl/alm_cfg_if.sv @@
interface alm_cfg_if import alm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/alm_ram.sv @@
module alm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/audio_level_meter_top.sv @@
// level meter: per-channel moving sum of squares and sliding-window peak, all-time peak over all channels
// after reset a clearing pass zeroes both memories; no request is taken meanwhile, config
// writes are; reset sets the windows to 4410 and 65536, channel state and overall peak to zero
// one request at a time: the next is taken only after the result register has been loaded,
// which can stall on level.ready; the walk up the max tree (up to 16 levels) goes through
// the single read port of the tree memory
module audio_level_meter_top import alm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	alm_in_if.sink   audio,
	alm_out_if.source level,
	alm_cfg_if.sink  cfg
);

	// sequencer
	state_t state_q, state_d;
	logic [TREE_AW-1:0] clr_q;

	// config registers
	logic [RMS_WIN_W-1:0]  rms_win_q;
	logic [PEAK_WIN_W-1:0] peak_win_q;

	// per-channel state
	logic [RMS_POS_W-1:0]  rms_pos_q [CHANNELS];
	logic [PEAK_POS_W-1:0] peak_pos_q [CHANNELS];
	logic [SUM_W-1:0]      sum_q [CHANNELS];
	logic [MAG_W-1:0]      glob_q;

	// working registers for the request in flight
	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] bits_q;
	logic [MAG_W-1:0]    mag_q;
	logic [RMS_POS_W-1:0]  rp_q;
	logic [PEAK_POS_W-1:0] pp_q;
	logic [NODE_W-1:0]   node_q;
	logic [MAG_W-1:0]    cur_q;
	logic [MAG_W-1:0]    v_q;
	logic [SQ_W-1:0]     mul_q;

	// result register
	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [SUM_W-1:0]    out_sum_q;
	logic [MAG_W-1:0]    out_peak_q;
	logic [MAG_W-1:0]    out_glob_q;

	// effective windows
	logic [RMS_WIN_W-1:0]  rw;
	logic [PEAK_WIN_W-1:0] pw;
	logic [PEAK_WIN_W-1:0] leaves;

	// memory ports
	logic                rms_we;
	logic [RMS_AW-1:0]   rms_waddr, rms_raddr;
	logic [SAMPLE_W-1:0] rms_wdata, rms_rdata;
	logic                tree_we;
	logic [TREE_AW-1:0]  tree_waddr, tree_raddr;
	logic [MAG_W-1:0]    tree_wdata, tree_rdata;

	// misc datapath
	logic                accept;
	logic                out_load;
	logic [CH_W-1:0]     in_ch;
	logic [RMS_POS_W-1:0]  rp_in;
	logic [PEAK_POS_W-1:0] pp_in;
	logic [MAG_W-1:0]    mul_a;
	logic [MAG_W-1:0]    sib_max;
	logic [NODE_W-1:0]   parent;
	logic                parent_same;
	logic [MAG_W-1:0]    glob_next;
	logic [RMS_WIN_W-1:0]  rp_inc;
	logic [PEAK_WIN_W-1:0] pp_inc;

	assign rw = clamp_rms(rms_win_q);
	assign pw = clamp_peak(peak_win_q);
	assign leaves = pow2_ceil(pw);

	assign cfg.ready = 1'b1;

	// channel field is as wide as the channel count needs, so it is the effective channel
	assign in_ch = audio.channel;
	// a position left beyond a lowered window restarts at zero
	assign rp_in = (RMS_WIN_W'(rms_pos_q[in_ch]) >= rw) ? '0 : rms_pos_q[in_ch];
	assign pp_in = (PEAK_WIN_W'(peak_pos_q[in_ch]) >= pw) ? '0 : peak_pos_q[in_ch];

	assign accept = audio.valid && audio.ready;

	assign rp_inc = RMS_WIN_W'(rp_q) + 1'b1;
	assign pp_inc = PEAK_WIN_W'(pp_q) + 1'b1;

	// shared squarer: new sample while the old one is read, old sample after
	assign mul_a = (state_q == ST_ROLD) ? magnitude(rms_rdata) : mag_q;

	// one tree level: max with the sibling, then compare with the stored parent
	assign sib_max = (cur_q > tree_rdata) ? cur_q : tree_rdata;
	assign parent = node_q >> 1;
	assign parent_same = (tree_rdata == v_q);

	assign glob_next = (mag_q > glob_q) ? mag_q : glob_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || level.ready);

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		audio.ready = 1'b0;
		rms_we = 1'b0;
		rms_waddr = {ch_q, rp_q};
		rms_wdata = bits_q;
		rms_raddr = {ch_q, rp_q};
		tree_we = 1'b0;
		tree_waddr = {ch_q, node_q};
		tree_wdata = mag_q;
		tree_raddr = {ch_q, node_q ^ NODE_W'(1)};
		case (state_q)
			ST_CLEAR: begin
				rms_we = 1'b1;
				rms_waddr = clr_q[RMS_AW-1:0];
				rms_wdata = '0;
				tree_we = 1'b1;
				tree_waddr = clr_q;
				tree_wdata = '0;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				audio.ready = 1'b1;
				if (audio.valid) begin
					state_d = ST_RRD;
				end
			end
			ST_RRD: begin
				state_d = ST_ROLD;
			end
			ST_ROLD: begin
				// old entry is on the read port; overwrite it with the new sample
				rms_we = 1'b1;
				state_d = ST_RSUB;
			end
			ST_RSUB: begin
				state_d = ST_LEAF;
			end
			ST_LEAF: begin
				// leaf write, sibling read
				tree_we = 1'b1;
				if (node_q == NODE_W'(1)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PAR;
				end
			end
			ST_PAR: begin
				tree_raddr = {ch_q, parent};
				state_d = ST_CMP;
			end
			ST_CMP: begin
				tree_raddr = {ch_q, parent ^ NODE_W'(1)};
				if (parent_same) begin
					// walk stops early once a parent already holds the max
					state_d = ST_DONE;
				end else begin
					tree_we = 1'b1;
					tree_waddr = {ch_q, parent};
					tree_wdata = v_q;
					state_d = (parent == NODE_W'(1)) ? ST_DONE : ST_PAR;
				end
			end
			ST_DONE: begin
				tree_raddr = {ch_q, NODE_W'(1)};
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// root read held until the result register frees up
				tree_raddr = {ch_q, NODE_W'(1)};
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// config writes, taken at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rms_win_q <= RMS_WINDOW_RST;
			peak_win_q <= PEAK_WINDOW_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RMS_WINDOW:  rms_win_q <= cfg.data[RMS_WIN_W-1:0];
				REG_PEAK_WINDOW: peak_win_q <= cfg.data[PEAK_WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// per-channel state and global peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rms_pos_q[i] <= '0;
				peak_pos_q[i] <= '0;
				sum_q[i] <= '0;
			end
			glob_q <= '0;
		end else begin
			case (state_q)
				ST_ROLD: begin
					// add new square (modulo 2^44)
					sum_q[ch_q] <= sum_q[ch_q] + SUM_W'(mul_q);
				end
				ST_RSUB: begin
					// drop the square of the entry just overwritten
					sum_q[ch_q] <= sum_q[ch_q] - SUM_W'(mul_q);
					rms_pos_q[ch_q] <= (rp_inc >= rw) ? '0 : rp_inc[RMS_POS_W-1:0];
				end
				ST_OUT: begin
					if (out_load) begin
						peak_pos_q[ch_q] <= (pp_inc >= pw) ? '0 : pp_inc[PEAK_POS_W-1:0];
						glob_q <= glob_next;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		mul_q <= SQ_W'(mul_a) * SQ_W'(mul_a);
		if (accept) begin
			ch_q <= in_ch;
			bits_q <= audio.sample;
			mag_q <= magnitude(audio.sample);
			cur_q <= magnitude(audio.sample);
			rp_q <= rp_in;
			pp_q <= pp_in;
			node_q <= leaves + PEAK_WIN_W'(pp_in);
		end
		if (state_q == ST_PAR) begin
			v_q <= sib_max;
		end
		if (state_q == ST_CMP && !parent_same) begin
			cur_q <= v_q;
			node_q <= parent;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (level.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q <= ch_q;
			out_sum_q <= sum_q[ch_q];
			out_peak_q <= tree_rdata;
			out_glob_q <= glob_next;
		end
	end

	assign level.valid = out_valid_q;
	assign level.channel_out = out_ch_q;
	assign level.sum_of_squares = out_sum_q;
	assign level.window_peak = out_peak_q;
	assign level.overall_peak = out_glob_q;

	// sample history ring, both channels
	alm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RMS_WORDS)
	) u_rms_ram (
		.clk(clk),
		.we(rms_we),
		.waddr(rms_waddr),
		.wdata(rms_wdata),
		.raddr(rms_raddr),
		.rdata(rms_rdata)
	);

	// heap-ordered max trees, both channels, root at node 1
	alm_ram #(
		.WIDTH(MAG_W),
		.DEPTH(TREE_WORDS)
	) u_tree_ram (
		.clk(clk),
		.we(tree_we),
		.waddr(tree_waddr),
		.wdata(tree_wdata),
		.raddr(tree_raddr),
		.rdata(tree_rdata)
	);

endmodule
